// ===== rtl/core/wrpose_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpose_pkg: shared constants for the world-to-robot pose transform
// Widths, the gain compensation constant and the CORDIC arctangent table
// used by the top level and by the rotation stages.
// ----------------------------------------------------------------------------
package wrpose_pkg;

    localparam int DEF_CORDIC_STAGES  = 16;
    localparam int DEF_POSITION_WIDTH = 24;

    // Heading fields are binary angles, 65536 units per turn.
    localparam int HEADING_W = 16;

    // Internal angle: 2^32 units per turn, with two bits of headroom.
    localparam int ANGLE_W = 32;
    localparam int ZW      = ANGLE_W + 2;

    // Fraction bits kept below the position LSB through the rotation.
    localparam int GUARD_BITS = 16;

    // Extra datapath bits over the position width: one for the difference,
    // the guard bits, and room for the rotated vector magnitude.
    localparam int CORDIC_EXTRA_BITS = 19;

    // Inverse of the limit CORDIC gain, Q30, and its fraction bit count.
    localparam int GAIN_Q30  = 652032874;
    localparam int GAIN_FRAC = 30;
    localparam int GAIN_W    = 31;

    localparam int ATAN_TABLE_LEN = 24;

    // atan(2^-idx) in 2^32-per-turn units.
    function automatic logic [ANGLE_W-1:0] atan_turn32(input int idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/wrpose_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpose_cordic_stage: one registered CORDIC micro-rotation
// Rotates (x, y) by +/- atan(2^-SHIFT) toward zero residual angle and
// carries the heading difference and the valid bit along.
// ----------------------------------------------------------------------------
module wrpose_cordic_stage
    import wrpose_pkg::*;
#(
    parameter int DATA_W = DEF_POSITION_WIDTH + CORDIC_EXTRA_BITS,
    parameter int SHIFT  = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  logic signed [ZW-1:0]     i_z,
    input  logic [HEADING_W-1:0]     i_heading,
    output logic                     o_vld,
    output logic signed [DATA_W-1:0] o_x,
    output logic signed [DATA_W-1:0] o_y,
    output logic signed [ZW-1:0]     o_z,
    output logic [HEADING_W-1:0]     o_heading
);

    localparam logic [ANGLE_W-1:0] ATAN = atan_turn32(SHIFT);

    logic                     r_vld;
    logic signed [DATA_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0]     r_z, n_z;
    logic [HEADING_W-1:0]     r_heading;
    logic signed [DATA_W-1:0] xs, ys;
    logic signed [ZW-1:0]     atan_ext;

    assign xs       = i_x >>> SHIFT;
    assign ys       = i_y >>> SHIFT;
    assign atan_ext = signed'({{(ZW-ANGLE_W){1'b0}}, ATAN});

    always_comb begin
        if (!i_z[ZW-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - atan_ext;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + atan_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_heading <= i_heading;
        end
    end

    assign o_vld     = r_vld;
    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_z       = r_z;
    assign o_heading = r_heading;

endmodule

// ===== rtl/core/world_to_robot_frame_pose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_robot_frame_pose: target pose expressed in the robot's frame
// Subtracts the robot position, rotates by minus the robot heading with a
// pipelined CORDIC, and returns the wrapped heading difference.
// ----------------------------------------------------------------------------
// Each input word carries a target pose and the robot's own pose in world
// coordinates; the output word gives the target in the robot frame (x along
// the forward axis, y along the left axis) and the heading difference
// target_heading - own_heading wrapped to a signed half-turn range (a half
// turn reads as -32768). The block keeps no state and returns exactly one
// output word per input word, in order. It is a fully pipelined datapath:
// a new word can be taken on every clock unless a stalled output has filled
// the pipe; each word goes through the difference, gain multiply, quadrant
// pre-rotation, one register per micro-rotation, rounding and saturation
// stages. Each stage has its own valid bit and advances whenever it is
// empty or the stage after it advances, so a stalled output only holds back
// as many words as are already queued behind it; empty slots are filled
// meanwhile. The position result is rounded to nearest and clamps to the
// output range, which in-range inputs reach only through rounding noise.
// ----------------------------------------------------------------------------
module world_to_robot_frame_pose
    import wrpose_pkg::*;
#(
    parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES,
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    localparam int IN_BITS   = 4 * POSITION_WIDTH + 2 * HEADING_W,
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 2 * (POSITION_WIDTH + 2) + HEADING_W,
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input word.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0 up: target_x, target_y, target_heading, own_x, own_y,
    // own_heading, then zero padding to whole bytes.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Output word.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0 up: local_x, local_y, local_heading, then zero padding.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PW  = POSITION_WIDTH;
    localparam int OW  = PW + 2;               // output position width
    localparam int DW  = PW + 1;               // position difference width
    localparam int PRW = DW + GAIN_W;          // gain product width
    localparam int CW  = PW + CORDIC_EXTRA_BITS;
    localparam int NUM_ROT = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                             CORDIC_STAGES : ATAN_TABLE_LEN;
    // Stages: difference, multiply, pre-rotation, micro-rotations, output.
    localparam int NS = NUM_ROT + 4;

    localparam int OFS_TX = 0;
    localparam int OFS_TY = OFS_TX + PW;
    localparam int OFS_TH = OFS_TY + PW;
    localparam int OFS_OX = OFS_TH + HEADING_W;
    localparam int OFS_OY = OFS_OX + PW;
    localparam int OFS_OH = OFS_OY + PW;

    localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(GAIN_Q30);
    localparam logic signed [CW-1:0] ROUND_HALF =
        {{(CW - GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS - 1){1'b0}}};

    // Per-stage valid bits and advance enables.
    logic [NS-1:0] w_vld;
    logic [NS-1:0] w_en;

    genvar g;
    generate
        for (g = 0; g < NS - 1; g++) begin : g_en
            assign w_en[g] = !w_vld[g] || w_en[g + 1];
        end
    endgenerate
    assign w_en[NS-1] = !w_vld[NS-1] || m_axis_tready;

    assign s_axis_tready = w_en[0];

    // ---------------------------------------------------------------- unpack
    logic signed [PW-1:0]  tx, ty, ox, oy;
    logic [HEADING_W-1:0]  th, oh;

    assign tx = s_axis_tdata[OFS_TX +: PW];
    assign ty = s_axis_tdata[OFS_TY +: PW];
    assign th = s_axis_tdata[OFS_TH +: HEADING_W];
    assign ox = s_axis_tdata[OFS_OX +: PW];
    assign oy = s_axis_tdata[OFS_OY +: PW];
    assign oh = s_axis_tdata[OFS_OH +: HEADING_W];

    // ------------------------------------------- stage 0: position difference
    logic                 r0_vld;
    logic signed [DW-1:0] r0_dx, r0_dy;
    logic [HEADING_W-1:0] r0_nh, r0_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en[0]) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_dx <= DW'(tx) - DW'(ox);
            r0_dy <= DW'(ty) - DW'(oy);
            // Rotation angle is minus the own heading; the heading
            // difference wraps naturally in 16 bits.
            r0_nh <= HEADING_W'(0) - oh;
            r0_hd <= th - oh;
        end
    end

    assign w_vld[0] = r0_vld;

    // ---------------------------------------- stage 1: gain compensation
    logic                  r1_vld;
    logic signed [PRW-1:0] r1_px, r1_py, n1_px, n1_py;
    logic [HEADING_W-1:0]  r1_nh, r1_hd;

    assign n1_px = r0_dx * GAIN;
    assign n1_py = r0_dy * GAIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en[1]) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_px <= n1_px;
            r1_py <= n1_py;
            r1_nh <= r0_nh;
            r1_hd <= r0_hd;
        end
    end

    assign w_vld[1] = r1_vld;

    // ------------------------------------ stage 2: scaling and half-turn flip
    logic signed [PRW-1:0] sx, sy;
    logic signed [CW-1:0]  x0, y0;
    logic [ANGLE_W-1:0]    z0;
    logic                  flip;
    logic                  r2_vld;
    logic signed [CW-1:0]  r2_x, r2_y;
    logic signed [ZW-1:0]  r2_z, n2_z;
    logic [HEADING_W-1:0]  r2_hd;

    assign sx   = r1_px >>> (GAIN_FRAC - GUARD_BITS);
    assign sy   = r1_py >>> (GAIN_FRAC - GUARD_BITS);
    assign x0   = sx[CW-1:0];
    assign y0   = sy[CW-1:0];
    assign z0   = {r1_nh, {(ANGLE_W - HEADING_W){1'b0}}};
    // The angle lies outside a quarter turn either side when its top two
    // bits differ; then negate the vector and move the angle by a half turn.
    assign flip = z0[ANGLE_W-1] ^ z0[ANGLE_W-2];
    assign n2_z = signed'({{(ZW - ANGLE_W + 1){z0[ANGLE_W-1] ^ flip}},
                           z0[ANGLE_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en[2]) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_x  <= flip ? -x0 : x0;
            r2_y  <= flip ? -y0 : y0;
            r2_z  <= n2_z;
            r2_hd <= r1_hd;
        end
    end

    assign w_vld[2] = r2_vld;

    // ------------------------------------------------ micro-rotation stages
    logic                 c_vld [NUM_ROT+1];
    logic signed [CW-1:0] c_x   [NUM_ROT+1];
    logic signed [CW-1:0] c_y   [NUM_ROT+1];
    logic signed [ZW-1:0] c_z   [NUM_ROT+1];
    logic [HEADING_W-1:0] c_hd  [NUM_ROT+1];

    assign c_vld[0] = r2_vld;
    assign c_x[0]   = r2_x;
    assign c_y[0]   = r2_y;
    assign c_z[0]   = r2_z;
    assign c_hd[0]  = r2_hd;

    generate
        for (g = 0; g < NUM_ROT; g++) begin : g_rot
            wrpose_cordic_stage #(
                .DATA_W (CW),
                .SHIFT  (g)
            ) u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_en[g + 3]),
                .i_vld     (c_vld[g]),
                .i_x       (c_x[g]),
                .i_y       (c_y[g]),
                .i_z       (c_z[g]),
                .i_heading (c_hd[g]),
                .o_vld     (c_vld[g + 1]),
                .o_x       (c_x[g + 1]),
                .o_y       (c_y[g + 1]),
                .o_z       (c_z[g + 1]),
                .o_heading (c_hd[g + 1])
            );
            assign w_vld[g + 3] = c_vld[g + 1];
        end
    endgenerate

    // ------------------------------------ output stage: round and saturate
    logic signed [CW-1:0] rx, ry;
    logic [OW-1:0]        n_lx, n_ly;
    logic                 r_ovld;
    logic [OW-1:0]        r_lx, r_ly;
    logic [HEADING_W-1:0] r_lh;

    function automatic logic [OW-1:0] sat_pos(input logic signed [CW-1:0] v);
        logic [CW-OW:0] upper;
        logic [OW-1:0]  res;
        upper = v[CW-1:OW-1];
        if (&upper || ~|upper) begin
            res = v[OW-1:0];
        end else begin
            res = {v[CW-1], {(OW - 1){~v[CW-1]}}};
        end
        return res;
    endfunction

    assign rx   = (c_x[NUM_ROT] + ROUND_HALF) >>> GUARD_BITS;
    assign ry   = (c_y[NUM_ROT] + ROUND_HALF) >>> GUARD_BITS;
    assign n_lx = sat_pos(rx);
    assign n_ly = sat_pos(ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en[NS-1]) begin
            r_ovld <= c_vld[NUM_ROT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_lx <= n_lx;
            r_ly <= n_ly;
            r_lh <= c_hd[NUM_ROT];
        end
    end

    assign w_vld[NS-1] = r_ovld;

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, r_lh, r_ly, r_lx};

endmodule

// ===== tb/sv/world_to_robot_frame_pose_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_robot_frame_pose_tb: self-checking bench for the robot frame pose
// Streams world pose pairs into the block and checks every output word
// against an in-bench fixed-point CORDIC predictor. Both ports idle at
// random, and the output port holds off for long stretches to fill the pipe.
// ----------------------------------------------------------------------------
module world_to_robot_frame_pose_tb
    import wrpose_pkg::*;
;

    localparam int CORDIC_STAGES = DEF_CORDIC_STAGES;
    localparam int PW    = DEF_POSITION_WIDTH;
    localparam int OW    = PW + 2;
    localparam int IN_W  = ((4 * PW + 2 * HEADING_W + 7) / 8) * 8;
    localparam int OUT_W = ((2 * OW + HEADING_W + 7) / 8) * 8;

    localparam longint POS_MAX = (64'sd1 <<< (PW - 1)) - 1;
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam longint OUT_MAX = (64'sd1 <<< (OW - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam longint QUARTER_TURN32 = 64'sd1 <<< 30;
    localparam longint INV_GAIN_Q30   = 64'sd652032874;

    localparam int RANDOM_WORDS = 1030;
    localparam int LONG_HOLD    = 150;

    // atan(2^-i) in 2^32-per-turn units, one entry per micro-rotation.
    localparam logic [31:0] STEP_ANGLE [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic signed [PW-1:0]        target_x;
        logic signed [PW-1:0]        target_y;
        logic signed [HEADING_W-1:0] target_heading;
        logic signed [PW-1:0]        own_x;
        logic signed [PW-1:0]        own_y;
        logic signed [HEADING_W-1:0] own_heading;
    } t_world_pose_pair;

    typedef struct packed {
        logic signed [OW-1:0]        local_x;
        logic signed [OW-1:0]        local_y;
        logic signed [HEADING_W-1:0] local_heading;
    } t_local_pose;

    // Holds the robot frame poses still owed by the block, oldest first.
    class t_robot_frame_scoreboard;
        t_local_pose expected_local_poses[$];
        int          failures;

        function new();
            failures = 0;
        endfunction

        function automatic t_local_pose to_robot_frame(t_world_pose_pair p);
            longint             x, y, z, xs, ys, rx, ry;
            logic [15:0]        neg_heading;
            logic signed [31:0] z32;
            t_local_pose        r;
            // Gain compensation up front, leaving 16 fraction bits.
            x = ((longint'(p.target_x) - longint'(p.own_x)) * INV_GAIN_Q30) >>> 14;
            y = ((longint'(p.target_y) - longint'(p.own_y)) * INV_GAIN_Q30) >>> 14;
            // Rotate by minus the own heading, as a 32-bit binary angle.
            neg_heading = -p.own_heading;
            z32 = {neg_heading, 16'h0000};
            z = z32;
            if (z >= QUARTER_TURN32 || z < -QUARTER_TURN32) begin
                // Outside the CORDIC range: negate the vector, move by half a turn.
                x = -x;
                y = -y;
                z32 = z32 + 32'h80000000;
                z = z32;
            end
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(STEP_ANGLE[i]);
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(STEP_ANGLE[i]);
                end
            end
            rx = (x + 64'sd32768) >>> 16;
            ry = (y + 64'sd32768) >>> 16;
            if (rx > OUT_MAX) rx = OUT_MAX;
            if (rx < OUT_MIN) rx = OUT_MIN;
            if (ry > OUT_MAX) ry = OUT_MAX;
            if (ry < OUT_MIN) ry = OUT_MIN;
            r.local_x = rx[OW-1:0];
            r.local_y = ry[OW-1:0];
            r.local_heading = p.target_heading - p.own_heading;
            return r;
        endfunction

        function void note_world_pose(t_world_pose_pair p);
            expected_local_poses.push_back(to_robot_frame(p));
        endfunction

        function void report(string what, longint want, longint got);
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        endfunction

        function void check_local_pose(t_local_pose got);
            t_local_pose want;
            if (expected_local_poses.size() == 0) begin
                failures++;
                $display("%0t ns: output word, expected none, actual %0d %0d %0d",
                         $time, got.local_x, got.local_y, got.local_heading);
            end else begin
                want = expected_local_poses.pop_front();
                if (got.local_x != want.local_x)
                    report("local_x", want.local_x, got.local_x);
                if (got.local_y != want.local_y)
                    report("local_y", want.local_y, got.local_y);
                if (got.local_heading != want.local_heading)
                    report("local_heading", want.local_heading, got.local_heading);
            end
        endfunction

        function int poses_in_flight();
            return expected_local_poses.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // From bit 0 up: target_x, target_y, target_heading, own_x, own_y,
    // own_heading.
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // From bit 0 up: local_x, local_y, local_heading, then zero padding.
    logic [OUT_W-1:0] m_axis_tdata;

    t_robot_frame_scoreboard pose_sb = new();

    // Idle rates in percent, changed from phase to phase.
    int send_idle_pct = 25;
    int recv_stall_pct = 25;
    int results_taken = 0;

    world_to_robot_frame_pose #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .POSITION_WIDTH(PW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 8);
        end
        return $urandom_range(3, 1);
    endfunction

    // Offers one pose pair and returns at the edge that accepts it. Valid
    // stays high into the next word unless a gap is drawn.
    task automatic drive_pose(input longint tx, input longint ty, input longint th,
                              input longint ox, input longint oy, input longint oh);
        t_world_pose_pair p;
        int               gap;
        p.target_x       = tx[PW-1:0];
        p.target_y       = ty[PW-1:0];
        p.target_heading = th[HEADING_W-1:0];
        p.own_x          = ox[PW-1:0];
        p.own_y          = oy[PW-1:0];
        p.own_heading    = oh[HEADING_W-1:0];
        s_axis_tdata  <= {p.own_heading, p.own_y, p.own_x,
                          p.target_heading, p.target_y, p.target_x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pose_sb.note_world_pose(p);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Output side: checks each accepted word and draws the next ready.
    initial begin
        int hold_left;
        t_local_pose got;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.local_x       = m_axis_tdata[OW-1:0];
                got.local_y       = m_axis_tdata[2*OW-1:OW];
                got.local_heading = m_axis_tdata[2*OW+HEADING_W-1:2*OW];
                pose_sb.check_local_pose(got);
                results_taken++;
                // Long hold-offs while the input side keeps offering words.
                if (results_taken == 200 || results_taken == 700) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if ($urandom_range(99) < recv_stall_pct) begin
                m_axis_tready <= 1'b0;
                hold_left = pick_gap() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int     kind;
        longint tx, ty, ox, oy, th, oh;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Position extremes, the largest difference vectors and headings
        // around the quarter-turn edges of the pre-rotation.
        drive_pose(0, 0, 0, 0, 0, 0);
        drive_pose(POS_MAX, POS_MAX, 32767, POS_MIN, POS_MIN, -32768);
        drive_pose(POS_MIN, POS_MIN, -32768, POS_MAX, POS_MAX, 32767);
        drive_pose(POS_MAX, POS_MIN, -16384, POS_MIN, POS_MAX, 16384);
        drive_pose(POS_MIN, POS_MAX, 16384, POS_MAX, POS_MIN, -16384);
        drive_pose(POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN, 8192);
        drive_pose(POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, -24576);
        drive_pose(POS_MAX, POS_MIN, 100, POS_MIN, POS_MAX, 24576);
        drive_pose(1000, -700, 5, 0, 0, 16383);
        drive_pose(1000, -700, 5, 0, 0, 16385);
        drive_pose(1000, -700, 5, 0, 0, -16383);
        drive_pose(1000, -700, 5, 0, 0, -16385);
        // Half-turn heading difference reads as the most negative heading.
        drive_pose(12345, 678, 0, -9876, 54, -32768);
        drive_pose(1, 0, 32767, 0, 0, -1);
        drive_pose(0, -1, -1, 0, 0, 32767);
        drive_pose(-1, 1, 1, 0, 0, 1);
        drive_pose(3, -3, 0, 2, -2, 12000);
        drive_pose(POS_MAX, 0, 7, POS_MAX, 0, -7);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 350) begin
                // A stretch with no idling on either side.
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (n == 650) begin
                send_idle_pct = 10;
                recv_stall_pct = 50;
            end
            kind = $urandom_range(9);
            if (kind < 5) begin
                tx = longint'($urandom);
                ty = longint'($urandom);
                ox = longint'($urandom);
                oy = longint'($urandom);
                th = longint'($urandom);
                oh = longint'($urandom);
            end else if (kind < 8) begin
                // Target close to the robot, where rounding matters most.
                tx = longint'($urandom_range(8388608)) - 4194304;
                ty = longint'($urandom_range(8388608)) - 4194304;
                ox = tx + longint'($urandom_range(8192)) - 4096;
                oy = ty + longint'($urandom_range(8192)) - 4096;
                th = longint'($urandom);
                oh = longint'($urandom);
            end else begin
                // Own heading at or next to a multiple of a quarter turn.
                tx = longint'($urandom);
                ty = longint'($urandom);
                ox = longint'($urandom);
                oy = longint'($urandom);
                oh = 16384 * longint'($urandom_range(3)) + longint'($urandom_range(2)) - 1;
                th = ($urandom_range(1) == 0) ? oh + 32768 : longint'($urandom);
            end
            drive_pose(tx, ty, th, ox, oy, oh);
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 25;

        while (pose_sb.poses_in_flight() != 0) @(posedge i_clk);
        // Let any stray word surface before the verdict.
        repeat (CORDIC_STAGES + 12) @(posedge i_clk);
        if (pose_sb.failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("%0t ns: timeout", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
